[rtl/pcmrl_pkg.sv]
// ----------------------------------------------------------------------------
// pcmrl_pkg
// Shared types, kind tables and period constants of the per-channel message
// rate limiter.
// ----------------------------------------------------------------------------
package pcmrl_pkg;

    localparam int PER_KINDS = 13;
    localparam int IRR_KINDS = 14;
    localparam int CHANNELS  = 4;
    localparam int ID_W      = 8;
    localparam int TIME_W    = 32;
    localparam int PER_IDX_W = $clog2(PER_KINDS);

    typedef logic [TIME_W-1:0]                t_time;
    typedef logic [CHANNELS-1:0]              t_mask;
    typedef logic [CHANNELS-1:0][TIME_W-1:0]  t_row;
    typedef logic [ID_W-1:0]                  t_id;

    typedef enum logic [1:0] {
        ST_SENT        = 2'd0,
        ST_BUSY        = 2'd1,
        ST_NOT_ALLOWED = 2'd2,
        ST_UNKNOWN     = 2'd3
    } t_status;

    typedef struct packed {
        logic                 per_hit;
        logic [PER_IDX_W-1:0] per_idx;
        logic                 irr_hit;
        t_mask                irr_mask;
    } t_kind;

    localparam t_time P_NEVER = '1;
    localparam t_time P_0     = TIME_W'(0);
    localparam t_time P_200   = TIME_W'(200);
    localparam t_time P_500   = TIME_W'(500);
    localparam t_time P_1S    = TIME_W'(1000);
    localparam t_time P_5S    = TIME_W'(5000);
    localparam t_time P_10S   = TIME_W'(10000);
    localparam t_time P_30S   = TIME_W'(30000);
    localparam t_time P_10MIN = TIME_W'(600000);

    localparam t_id PER_IDS [PER_KINDS] = '{
        8'd0, 8'd1, 8'd24, 8'd33, 8'd26, 8'd29, 8'd30, 8'd34, 8'd74, 8'd109,
        8'd147, 8'd231, 8'd65
    };

    // Each row is written cellular, satellite, long-range radio, uart: channel 0 last.
    localparam t_row PER_PERIOD [PER_KINDS] = '{
        {P_NEVER, P_10MIN, P_10S,   P_5S},
        {P_NEVER, P_10MIN, P_30S,   P_10S},
        {P_NEVER, P_10MIN, P_30S,   P_0},
        {P_NEVER, P_10MIN, P_30S,   P_200},
        {P_NEVER, P_NEVER, P_30S,   P_1S},
        {P_NEVER, P_10MIN, P_30S,   P_500},
        {P_NEVER, P_10MIN, P_30S,   P_500},
        {P_NEVER, P_NEVER, P_30S,   P_1S},
        {P_NEVER, P_10MIN, P_30S,   P_500},
        {P_NEVER, P_NEVER, P_NEVER, P_30S},
        {P_NEVER, P_10MIN, P_30S,   P_30S},
        {P_NEVER, P_NEVER, P_NEVER, P_NEVER},
        {P_NEVER, P_10MIN, P_30S,   P_10S}
    };

    localparam t_id IRR_IDS [IRR_KINDS] = '{
        8'd11, 8'd39, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd46, 8'd47,
        8'd76, 8'd77, 8'd131, 8'd253
    };

    localparam t_mask IRR_MASK [IRR_KINDS] = '{
        4'h2, 4'h1, 4'h4, 4'h1, 4'h2, 4'h7, 4'h1, 4'h1, 4'h7, 4'h1,
        4'h3, 4'h3, 4'h1, 4'h1
    };

endpackage

[rtl/per_channel_message_rate_limiter_top.sv]
// ----------------------------------------------------------------------------
// per_channel_message_rate_limiter_top
// Per-channel message rate limiter with a registered input stage and a
// registered result stage.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle when the output side does not stall.
// The ID is matched as the item is accepted, which also reads the kind's row of
// last send times; while the item sits in the input stage the four channel
// checks run in parallel, and as it moves on the row is written back and the
// result is registered in the result stage. A new item is taken whenever the
// input stage is empty or moves on. All stored times read as zero after reset
// without a clearing pass, so items are taken from the first cycle on.
module per_channel_message_rate_limiter_top
    import pcmrl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [7:0] msg_id, [39:8] now_ms
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [3:0] channel_mask, [5:4] status, [7:6] zero
);

    t_kind   in_kind;
    t_kind   r_s1_kind;
    t_time   r_s1_now;
    logic    r_s1_valid;
    t_row    last_row;
    t_row    next_row;
    t_mask   mask;
    t_status status;
    t_mask   r_out_mask;
    t_status r_out_status;
    logic    r_out_valid;
    logic    out_ready;
    logic    s1_adv;
    logic    in_acc;

    assign out_ready  = !r_out_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && out_ready;
    assign o_s_tready = !r_s1_valid || out_ready;
    assign in_acc     = i_s_tvalid && o_s_tready;

    pcmrl_kind_lookup u_lookup (
        .i_msg_id (i_s_tdata[7:0]),
        .o_kind   (in_kind)
    );

    pcmrl_time_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc && in_kind.per_hit),
        .i_rd_addr (in_kind.per_idx),
        .i_wr_en   (s1_adv && r_s1_kind.per_hit),
        .i_wr_addr (r_s1_kind.per_idx),
        .i_wr_data (next_row),
        .o_rd_data (last_row)
    );

    pcmrl_channel_eval u_eval (
        .i_kind   (r_s1_kind),
        .i_now_ms (r_s1_now),
        .i_last   (last_row),
        .o_next   (next_row),
        .o_mask   (mask),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind <= in_kind;
            r_s1_now  <= i_s_tdata[39:8];
        end
        if (s1_adv) begin
            r_out_mask   <= mask;
            r_out_status <= status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_status, r_out_mask};

endmodule

[rtl/pcmrl_kind_lookup.sv]
// ----------------------------------------------------------------------------
// pcmrl_kind_lookup
// Matches a message ID against the periodic and irregular kind tables,
// first matching row winning in each.
// ----------------------------------------------------------------------------
module pcmrl_kind_lookup
    import pcmrl_pkg::*;
(
    input  t_id   i_msg_id,
    output t_kind o_kind
);

    always_comb begin
        o_kind = '0;
        // Walking downwards lets the lowest matching row overwrite the others.
        for (int k = PER_KINDS - 1; k >= 0; k--) begin
            if (PER_IDS[k] == i_msg_id) begin
                o_kind.per_hit = 1'b1;
                o_kind.per_idx = PER_IDX_W'(k);
            end
        end
        for (int k = IRR_KINDS - 1; k >= 0; k--) begin
            if (IRR_IDS[k] == i_msg_id) begin
                o_kind.irr_hit  = 1'b1;
                o_kind.irr_mask = IRR_MASK[k];
            end
        end
    end

endmodule

[rtl/pcmrl_time_store.sv]
// ----------------------------------------------------------------------------
// pcmrl_time_store
// Last send times, one row of all channels per periodic kind. One write and
// one registered read per cycle; rows never written read as zero.
// ----------------------------------------------------------------------------
module pcmrl_time_store
    import pcmrl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [PER_IDX_W-1:0] i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [PER_IDX_W-1:0] i_wr_addr,
    input  t_row                 i_wr_data,
    output t_row                 o_rd_data
);

    t_row                 r_mem [PER_KINDS];
    logic [PER_KINDS-1:0] r_row_valid;
    t_row                 r_rd_data;
    t_row                 r_fwd_data;
    logic                 r_rd_valid;
    logic                 r_fwd_sel;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
            r_fwd_sel   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_row_valid[i_rd_addr];
                // A write to the same row in the read cycle is not yet in the array.
                r_fwd_sel  <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_fwd_sel  ? r_fwd_data :
                       r_rd_valid ? r_rd_data  : '0;

endmodule

[rtl/pcmrl_channel_eval.sv]
// ----------------------------------------------------------------------------
// pcmrl_channel_eval
// Decides per channel whether the period has run out, advances the stored
// times of the channels that fire and forms the result.
// ----------------------------------------------------------------------------
module pcmrl_channel_eval
    import pcmrl_pkg::*;
(
    input  t_kind   i_kind,
    input  t_time   i_now_ms,
    input  t_row    i_last,
    output t_row    o_next,
    output t_mask   o_mask,
    output t_status o_status
);

    t_row  period;
    t_mask fire;

    assign period = PER_PERIOD[i_kind.per_idx];

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            // Elapsed time wraps modulo 2^32; an all-ones period can never be exceeded.
            fire[c]   = (i_now_ms - i_last[c]) > period[c];
            o_next[c] = fire[c] ? (i_last[c] + period[c]) : i_last[c];
        end
    end

    always_comb begin
        priority if (i_kind.per_hit) begin
            o_mask   = fire;
            o_status = (fire != '0) ? ST_SENT : ST_BUSY;
        end else if (i_kind.irr_hit) begin
            o_mask   = i_kind.irr_mask;
            o_status = (i_kind.irr_mask != '0) ? ST_SENT : ST_NOT_ALLOWED;
        end else begin
            o_mask   = '0;
            o_status = ST_UNKNOWN;
        end
    end

endmodule

[rtl/pcmrl_checker.sv]
// ----------------------------------------------------------------------------
// pcmrl_checker
// Port-level checks of the rate limiter: result hold, status coding and the
// count of items in flight.
// ----------------------------------------------------------------------------
module pcmrl_checker
    import pcmrl_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    logic [1:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[5:4] == ST_SENT) == (o_m_tdata[3:0] != 4'h0))
                       && (o_m_tdata[7:6] == 2'b00))
        else $error("status disagrees with channel mask");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_pending != 2'd0)
        else $error("result shown with no item in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd2 |-> !o_s_tready || i_m_tready)
        else $error("more than two items taken in");

endmodule

bind per_channel_message_rate_limiter_top pcmrl_checker u_pcmrl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
